// File: design/wbps_pkg.sv
// Shared types and constants of the wildcard byte pattern scan.
// No dependencies; every other file of the block refers to it by scoped names.
package wbps_pkg;

    // Fixed field widths
    localparam int ADDR_W    = 64;
    localparam int IMG_W     = 32;
    localparam int LEN_W     = 5;
    localparam int DISP_W    = 32;
    localparam int POS_W     = 40;
    localparam int CFG_IDX_W = 3;
    localparam int PAT_BYTES = 16;

    // Relative displacement: 32-bit word three bytes into the match, plus seven
    localparam int DISP_AT  = 3;
    localparam int DISP_ADD = 7;

    localparam logic [LEN_W-1:0]  REL_NEED  = LEN_W'(DISP_ADD);
    localparam logic [LEN_W-1:0]  MIN_NEED  = LEN_W'(1);
    localparam logic [LEN_W-1:0]  LEN_RESET = LEN_W'(1);
    localparam logic [ADDR_W-1:0] REL_BIAS  = ADDR_W'(DISP_ADD);
    localparam logic [POS_W-1:0]  POS_LIMIT = '1;
    localparam logic [POS_W-1:0]  POS_ONE   = POS_W'(1);

    typedef logic [7:0] t_byte;
    typedef logic [PAT_BYTES-1:0][7:0] t_pattern;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LO   = 3'd0,
        CFG_PAT_HI   = 3'd1,
        CFG_WILD     = 3'd2,
        CFG_PAT_LEN  = 3'd3,
        CFG_REL_MODE = 3'd4,
        CFG_BASE     = 3'd5,
        CFG_IMG_SIZE = 3'd6
    } t_cfg_index;

    // Decision of one scan, handed to the address resolve stage
    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  start;
        logic [DISP_W-1:0] disp;
        logic              rel;
    } t_hit;

endpackage

// File: design/wbps_cell.sv
// One window cell: holds one image byte, passes it to its older neighbour and
// compares the byte it is taking against the pattern byte aligned to it. Uses wbps_pkg.
module wbps_cell #(
    parameter int AGE      = 0,
    parameter int NEED_MAX = 16,
    parameter int LEN_CAP  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_shift,
    input  logic                                 i_clr,
    input  wbps_pkg::t_byte                      i_din,
    input  wbps_pkg::t_pattern                   i_pattern,
    input  logic [wbps_pkg::PAT_BYTES-1:0]       i_wild,
    input  logic [wbps_pkg::LEN_W-1:0]           i_len,
    output wbps_pkg::t_byte                      o_q,
    output wbps_pkg::t_byte                      o_next,
    output logic [NEED_MAX-1:0]                  o_ok
);

    wbps_pkg::t_byte r_byte;
    wbps_pkg::t_byte n_byte;

    // Take the neighbour's byte, or zero when a new scan clears the window
    always_comb begin
        n_byte = i_clr ? '0 : i_din;
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= n_byte;
        end
    end

    assign o_q    = r_byte;
    assign o_next = n_byte;

    // Bit g covers a lag of g+1 bytes: the aligned pattern byte is g - AGE.
    // Bytes outside the pattern, past the length, or wildcarded always pass.
    for (genvar g = 0; g < NEED_MAX; g++) begin : g_need
        localparam int J = g - AGE;
        if (J < 0 || J >= LEN_CAP) begin : g_out
            assign o_ok[g] = 1'b1;
        end else begin : g_cmp
            localparam logic [wbps_pkg::LEN_W-1:0] JL = J[wbps_pkg::LEN_W-1:0];
            assign o_ok[g] = (i_len <= JL) || i_wild[J] || (n_byte == i_pattern[J]);
        end
    end

endmodule

// File: design/wbps_resolve.sv
// Two-entry result pipe: holds scan decisions and resolves the match address,
// with the relative displacement folded in. Uses wbps_pkg.
module wbps_resolve (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  wbps_pkg::t_hit                i_hit,
    input  logic [wbps_pkg::ADDR_W-1:0]   i_base,
    input  logic                          i_stall,
    output logic                          o_full,
    output logic                          o_valid,
    output logic                          o_found,
    output logic [wbps_pkg::ADDR_W-1:0]   o_match_address
);

    logic                          r_a_valid;
    logic                          n_a_valid;
    wbps_pkg::t_hit                r_a;
    logic                          r_b_valid;
    logic                          n_b_valid;
    logic                          r_b_found;
    logic [wbps_pkg::ADDR_W-1:0]   r_b_addr;
    logic [wbps_pkg::ADDR_W-1:0]   n_b_addr;
    logic [wbps_pkg::ADDR_W-1:0]   rel_off;
    logic                          b_free;
    logic                          a_move;

    // Advance the decision into the output register whenever it is free
    always_comb begin
        b_free    = !r_b_valid || !i_stall;
        a_move    = r_a_valid && b_free;
        n_a_valid = i_load || (r_a_valid && !a_move);
        n_b_valid = a_move || (r_b_valid && i_stall);
    end

    // Resolve the address: base plus start, plus displacement and bias in relative mode
    always_comb begin
        rel_off = r_a.rel ? ({{(wbps_pkg::ADDR_W - wbps_pkg::DISP_W){r_a.disp[wbps_pkg::DISP_W-1]}},
                              r_a.disp} + wbps_pkg::REL_BIAS)
                          : '0;
        n_b_addr = r_a.found
                 ? (i_base + {{(wbps_pkg::ADDR_W - wbps_pkg::POS_W){1'b0}}, r_a.start} + rel_off)
                 : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            r_b_valid <= n_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a <= i_hit;
        end
        if (a_move) begin
            r_b_found <= r_a.found;
            r_b_addr  <= n_b_addr;
        end
    end

    // Full only while the held decision cannot move on in this cycle
    assign o_full          = r_a_valid && !b_free;
    assign o_valid         = r_b_valid;
    assign o_found         = r_b_found;
    assign o_match_address = r_b_addr;

endmodule

// File: design/wildcard_byte_pattern_scan.sv
// Wildcard byte pattern scan: image bytes stream in one per beat, with
// image_start on the first byte of each scan, and the block gives one result
// beat per scan: the first matching position (found, with its resolved
// address) or a not-found beat with address 0. A byte is taken in every cycle
// without a stall; each byte shifts through the row of window cells and is
// compared against all pattern alignments in the same cycle, so the rate is
// one byte per clock unless stalled. Results pass the held decision, then the output
// register of the two-entry result pipe; the input stalls only while both entries
// are full and the result beat is held off. The user must write configuration via
// the plain write port only while no result is pending; the block does not enforce it.
module wildcard_byte_pattern_scan #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wbps_pkg::ADDR_W-1:0]         i_cfg_data,
    // byte stream
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [7:0]                          i_scan_byte,
    input  logic                                i_image_start,
    // result stream
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_found,
    output logic [wbps_pkg::ADDR_W-1:0]         o_match_address
);

    localparam int LEN_CAP  = (MAX_PATTERN < wbps_pkg::PAT_BYTES) ? MAX_PATTERN
                                                                 : wbps_pkg::PAT_BYTES;
    localparam int NEED_MAX = (LEN_CAP > wbps_pkg::DISP_ADD) ? LEN_CAP : wbps_pkg::DISP_ADD;
    localparam int NIDX_W   = $clog2(NEED_MAX);
    localparam logic [wbps_pkg::LEN_W-1:0] LEN_CAP_L = LEN_CAP[wbps_pkg::LEN_W-1:0];

    // Configuration registers
    logic [wbps_pkg::ADDR_W-1:0]    r_pat_lo;
    logic [wbps_pkg::ADDR_W-1:0]    r_pat_hi;
    logic [wbps_pkg::PAT_BYTES-1:0] r_wild;
    logic [wbps_pkg::LEN_W-1:0]     r_pat_len;
    logic                           r_rel;
    logic [wbps_pkg::ADDR_W-1:0]    r_base;
    logic [wbps_pkg::IMG_W-1:0]     r_img_size;

    // Scan state
    logic                           r_done;
    logic                           n_done;
    logic [wbps_pkg::POS_W-1:0]     r_pos;
    logic [wbps_pkg::POS_W-1:0]     n_pos;

    wbps_pkg::t_pattern             pattern;
    wbps_pkg::t_byte                w_q    [MAX_PATTERN];
    wbps_pkg::t_byte                w_next [MAX_PATTERN];
    logic [NEED_MAX-1:0]            w_ok   [MAX_PATTERN];
    logic [NEED_MAX-1:0]            ok_all;

    logic                           in_acc;
    logic                           act;
    logic                           full;
    logic [wbps_pkg::LEN_W-1:0]     len;
    logic [wbps_pkg::LEN_W-1:0]     need;
    logic [wbps_pkg::LEN_W-1:0]     need_m1;
    logic [wbps_pkg::IMG_W-1:0]     positions;
    logic [wbps_pkg::POS_W-1:0]     need_p;
    logic [wbps_pkg::POS_W-1:0]     positions_p;
    logic [wbps_pkg::POS_W-1:0]     start_n;
    logic                           pos_ready;
    logic                           in_range;
    logic                           last_pos;
    logic                           hit;
    logic                           empty;
    logic                           emit;
    logic [wbps_pkg::DISP_W-1:0]    disp;
    wbps_pkg::t_hit                 hit_info;

    assign in_acc  = i_valid && !o_stall;
    assign act     = in_acc && (i_image_start || !r_done);
    assign pattern = {r_pat_hi, r_pat_lo};

    // Take configuration writes; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo   <= '0;
            r_pat_hi   <= '0;
            r_wild     <= '0;
            r_pat_len  <= wbps_pkg::LEN_RESET;
            r_rel      <= 1'b0;
            r_base     <= '0;
            r_img_size <= '0;
        end else if (i_cfg_we) begin
            case (wbps_pkg::t_cfg_index'(i_cfg_index))
                wbps_pkg::CFG_PAT_LO:   r_pat_lo   <= i_cfg_data;
                wbps_pkg::CFG_PAT_HI:   r_pat_hi   <= i_cfg_data;
                wbps_pkg::CFG_WILD:     r_wild     <= i_cfg_data[wbps_pkg::PAT_BYTES-1:0];
                wbps_pkg::CFG_PAT_LEN:  r_pat_len  <= i_cfg_data[wbps_pkg::LEN_W-1:0];
                wbps_pkg::CFG_REL_MODE: r_rel      <= i_cfg_data[0];
                wbps_pkg::CFG_BASE:     r_base     <= i_cfg_data;
                wbps_pkg::CFG_IMG_SIZE: r_img_size <= i_cfg_data[wbps_pkg::IMG_W-1:0];
                default: ;
            endcase
        end
    end

    // Row of window cells; the newest byte enters at the top cell
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_win
        wbps_pkg::t_byte din;
        logic            clr;
        if (k == MAX_PATTERN - 1) begin : g_head
            assign din = i_scan_byte;
            assign clr = 1'b0;
        end else begin : g_body
            assign din = w_q[k+1];
            assign clr = i_image_start;
        end
        wbps_cell #(
            .AGE      (MAX_PATTERN - 1 - k),
            .NEED_MAX (NEED_MAX),
            .LEN_CAP  (LEN_CAP)
        ) u_cell (
            .i_clk     (i_clk),
            .i_shift   (act),
            .i_clr     (clr),
            .i_din     (din),
            .i_pattern (pattern),
            .i_wild    (r_wild),
            .i_len     (len),
            .o_q       (w_q[k]),
            .o_next    (w_next[k]),
            .o_ok      (w_ok[k])
        );
    end

    // Combine the cell votes for every lag
    always_comb begin
        ok_all = '1;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            ok_all = ok_all & w_ok[k];
        end
    end

    // Effective length and evaluation lag
    always_comb begin
        len = (r_pat_len > LEN_CAP_L) ? LEN_CAP_L : r_pat_len;
        need = len;
        if (r_rel && need < wbps_pkg::REL_NEED) begin
            need = wbps_pkg::REL_NEED;
        end
        if (need < wbps_pkg::MIN_NEED) begin
            need = wbps_pkg::MIN_NEED;
        end
        need_m1 = need - wbps_pkg::MIN_NEED;
    end

    // Pick the displacement word for the current lag
    always_comb begin
        disp = '0;
        for (int n = wbps_pkg::DISP_ADD; n <= NEED_MAX; n++) begin
            if (need == n[wbps_pkg::LEN_W-1:0]) begin
                disp = {w_next[MAX_PATTERN - n + wbps_pkg::DISP_AT + 3],
                        w_next[MAX_PATTERN - n + wbps_pkg::DISP_AT + 2],
                        w_next[MAX_PATTERN - n + wbps_pkg::DISP_AT + 1],
                        w_next[MAX_PATTERN - n + wbps_pkg::DISP_AT]};
            end
        end
    end

    // Decide the start position that this beat completes
    always_comb begin
        n_pos = r_pos;
        if (i_image_start) begin
            n_pos = wbps_pkg::POS_ONE;
        end else if (r_pos != wbps_pkg::POS_LIMIT) begin
            n_pos = r_pos + wbps_pkg::POS_ONE;
        end
        positions = (r_img_size > {{(wbps_pkg::IMG_W - wbps_pkg::LEN_W){1'b0}}, len})
                  ? r_img_size - {{(wbps_pkg::IMG_W - wbps_pkg::LEN_W){1'b0}}, len}
                  : '0;
        need_p      = {{(wbps_pkg::POS_W - wbps_pkg::LEN_W){1'b0}}, need};
        positions_p = {{(wbps_pkg::POS_W - wbps_pkg::IMG_W){1'b0}}, positions};
        empty       = (positions == '0);
        pos_ready   = (n_pos >= need_p);
        start_n     = n_pos - need_p;
        in_range    = (start_n < positions_p);
        last_pos    = (start_n >= positions_p - wbps_pkg::POS_ONE);
        hit         = !empty && pos_ready && in_range && ok_all[need_m1[NIDX_W-1:0]];
        emit        = act && (empty || (pos_ready && (hit || last_pos)));
        n_done      = act ? emit : r_done;
        hit_info.found = hit;
        hit_info.start = start_n;
        hit_info.disp  = disp;
        hit_info.rel   = r_rel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b1;
            r_pos  <= '0;
        end else begin
            r_done <= n_done;
            if (act) begin
                r_pos <= n_pos;
            end
        end
    end

    wbps_resolve u_resolve (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (emit),
        .i_hit           (hit_info),
        .i_base          (r_base),
        .i_stall         (i_stall),
        .o_full          (full),
        .o_valid         (o_valid),
        .o_found         (o_found),
        .o_match_address (o_match_address)
    );

    assign o_stall = full;

    // A decision never lands on a full result pipe
    assert property (@(posedge i_clk) disable iff (!i_rst_n) emit |-> !full)
        else $error("scan decision taken while the result pipe is full");

    // A running scan has always counted at least one byte
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !r_done |-> r_pos != '0)
        else $error("scan running with an empty position count");

    // A not-found beat carries address zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> o_match_address == '0)
        else $error("not-found result with a nonzero address");

endmodule
